>>> hw/rtl/fbfla_pkg.sv
package fbfla_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int LEN_W      = 7;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] LINK_NULL = CNT_W'(MAX_BLOCKS);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] BS_NEVER  = 2'd0;
  localparam logic [1:0] BS_ACTIVE = 2'd1;
  localparam logic [1:0] BS_FREED  = 2'd2;

  typedef struct packed {
    logic latch;
    logic issue;
    logic fin;
  } ctl_t;

endpackage

>>> hw/rtl/fbfla_ram.sv
module fbfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/fbfla_ctrl.sv
module fbfla_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output fbfla_pkg::ctl_t    ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_FIN
  } state_t;

  state_t state_r;
  logic   busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_ISSUE;
            busy_r  <= 1'b1;
          end
        end
        S_ISSUE: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy      = busy_r;
  assign ctl.latch = start && !busy_r;
  assign ctl.issue = (state_r == S_ISSUE);
  assign ctl.fin   = (state_r == S_FIN);

endmodule

>>> hw/rtl/fbfla_dp.sv
module fbfla_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fbfla_pkg::ctl_t                ctl,
  input  logic [1:0]                     in_command,
  input  logic [fbfla_pkg::IDX_W-1:0]    in_block_index,
  input  logic                           cfg_we,
  input  logic [fbfla_pkg::LEN_W-1:0]    cfg_pool_length,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [fbfla_pkg::IDX_W-1:0]    out_granted_index,
  output logic [1:0]                     out_block_state,
  output logic                           out_list_nonempty
);

  localparam int IDX_W = fbfla_pkg::IDX_W;
  localparam int CNT_W = fbfla_pkg::CNT_W;
  localparam int NBLK  = fbfla_pkg::MAX_BLOCKS;

  logic [fbfla_pkg::LEN_W-1:0] pool_len_r;
  logic [1:0]                  cmd_r;
  logic [IDX_W-1:0]            idx_r;
  logic [IDX_W-1:0]            head_r;
  logic                        head_vld_r;
  logic [NBLK-1:0]             link_vld_r;
  logic [NBLK-1:0]             flag_vld_r;

  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [IDX_W-1:0]            out_granted_r;
  logic [1:0]                  out_bstate_r;
  logic                        out_nonempty_r;

  logic [CNT_W-1:0]            eff_n;
  logic                        idx_ok;
  logic [CNT_W-1:0]            head_plus;
  logic [CNT_W-1:0]            dflt_link;
  logic [CNT_W-1:0]            link_q;
  logic [CNT_W-1:0]            cur_link;
  logic [1:0]                  flag_q;
  logic [1:0]                  cur_flag;

  logic                        link_we;
  logic [CNT_W-1:0]            link_wdata;
  logic                        flag_we;
  logic [IDX_W-1:0]            flag_waddr;
  logic [1:0]                  flag_wdata;
  logic                        clr;
  logic [IDX_W-1:0]            head_nxt;
  logic                        head_vld_nxt;
  logic [1:0]                  status_nxt;
  logic [IDX_W-1:0]            granted_nxt;
  logic [1:0]                  bstate_nxt;

  always_comb begin
    if (pool_len_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (pool_len_r > fbfla_pkg::LEN_W'(NBLK)) begin
      eff_n = CNT_W'(NBLK);
    end else begin
      eff_n = CNT_W'(pool_len_r);
    end
  end

  assign idx_ok    = {1'b0, idx_r} < eff_n;
  assign head_plus = {1'b0, head_r} + CNT_W'(1);
  assign dflt_link = (head_plus < eff_n) ? head_plus : fbfla_pkg::LINK_NULL;
  assign cur_link  = link_vld_r[head_r] ? link_q : dflt_link;
  assign cur_flag  = flag_vld_r[idx_r] ? flag_q : fbfla_pkg::BS_NEVER;

  fbfla_ram #(.WIDTH(CNT_W), .DEPTH(NBLK)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (idx_r),
    .wdata (link_wdata),
    .re    (ctl.issue),
    .raddr (head_r),
    .rdata (link_q)
  );

  fbfla_ram #(.WIDTH(2), .DEPTH(NBLK)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (ctl.issue),
    .raddr (idx_r),
    .rdata (flag_q)
  );

  always_comb begin
    link_we      = 1'b0;
    link_wdata   = head_vld_r ? {1'b0, head_r} : fbfla_pkg::LINK_NULL;
    flag_we      = 1'b0;
    flag_waddr   = idx_r;
    flag_wdata   = fbfla_pkg::BS_FREED;
    clr          = 1'b0;
    head_nxt     = head_r;
    head_vld_nxt = head_vld_r;
    status_nxt   = fbfla_pkg::ST_OK;
    granted_nxt  = '0;
    bstate_nxt   = fbfla_pkg::BS_NEVER;
    case (cmd_r)
      fbfla_pkg::CMD_ALLOC: begin
        if (head_vld_r) begin
          granted_nxt = head_r;
          flag_we     = ctl.fin;
          flag_waddr  = head_r;
          flag_wdata  = fbfla_pkg::BS_ACTIVE;
          if (!cur_link[CNT_W-1]) begin
            head_nxt = cur_link[IDX_W-1:0];
          end else begin
            head_nxt     = '0;
            head_vld_nxt = 1'b0;
          end
        end else begin
          status_nxt = fbfla_pkg::ST_EMPTY;
        end
      end
      fbfla_pkg::CMD_FREE: begin
        if (idx_ok) begin
          link_we      = ctl.fin;
          flag_we      = ctl.fin;
          head_nxt     = idx_r;
          head_vld_nxt = 1'b1;
        end else begin
          status_nxt = fbfla_pkg::ST_RANGE;
        end
      end
      fbfla_pkg::CMD_CLEAR: begin
        clr          = 1'b1;
        head_nxt     = '0;
        head_vld_nxt = 1'b1;
      end
      fbfla_pkg::CMD_QUERY: begin
        if (idx_ok) begin
          bstate_nxt = cur_flag;
        end else begin
          status_nxt = fbfla_pkg::ST_RANGE;
        end
      end
      default: begin
        status_nxt = fbfla_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_len_r  <= fbfla_pkg::LEN_RESET;
      head_r      <= '0;
      head_vld_r  <= 1'b1;
      link_vld_r  <= '0;
      flag_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.fin;
      if (cfg_we) begin
        pool_len_r <= cfg_pool_length;
        head_r     <= '0;
        head_vld_r <= 1'b1;
        link_vld_r <= '0;
        flag_vld_r <= '0;
      end else if (ctl.fin) begin
        head_r     <= head_nxt;
        head_vld_r <= head_vld_nxt;
        if (clr) begin
          link_vld_r <= '0;
          flag_vld_r <= '0;
        end
        if (link_we) begin
          link_vld_r[idx_r] <= 1'b1;
        end
        if (flag_we) begin
          flag_vld_r[flag_waddr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= in_command;
      idx_r <= in_block_index;
    end
    if (ctl.fin) begin
      out_status_r   <= status_nxt;
      out_granted_r  <= granted_nxt;
      out_bstate_r   <= bstate_nxt;
      out_nonempty_r <= head_vld_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_r;
  assign out_block_state   = out_bstate_r;
  assign out_list_nonempty = out_nonempty_r;

endmodule

>>> hw/rtl/fixed_block_free_list_allocator.sv
// A command is latched when start is taken while idle; steps: link/state RAM read, then
// update and writeback (the out_ ports register it), then idle. Commands do not overlap.
// busy is high in read and update; results carry a one-cycle out_valid strobe, no stall.
// Reset (sync, rst_n low): length 64, all blocks linked in index order and never used.
// A pool_length write relinks the pool at once; cfg_ready is high only while idle.
module fixed_block_free_list_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_command,
  input  logic [fbfla_pkg::IDX_W-1:0]    in_block_index,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [fbfla_pkg::IDX_W-1:0]    out_granted_index,
  output logic [1:0]                     out_block_state,
  output logic                           out_list_nonempty,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fbfla_pkg::LEN_W-1:0]    cfg_pool_length
);

  fbfla_pkg::ctl_t ctl;
  logic            busy_w;

  assign busy      = busy_w;
  assign cfg_ready = !busy_w && !start;

  fbfla_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy_w),
    .ctl   (ctl)
  );

  fbfla_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .in_command        (in_command),
    .in_block_index    (in_block_index),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_pool_length   (cfg_pool_length),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_block_state   (out_block_state),
    .out_list_nonempty (out_list_nonempty)
  );

endmodule
